@@ hw/rtl/lwfs_pkg.sv @@
// Package for the LUT Walsh-Hadamard spectrum block.
// Holds widths, lane counts and the tag that travels with each coefficient.
// No dependencies.
package lwfs_pkg;

   localparam int MAX_INPUTS = 6;
   localparam int IDX_W      = 6;
   localparam int LANES      = 64;
   localparam int N_W        = 3;
   localparam int COEF_W     = 8;
   localparam int GROUPS     = 8;
   localparam int GROUP_SIZE = 8;
   localparam int GCNT_W     = 4;
   localparam int TOTAL_W    = 7;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 16;

   // Control that follows one coefficient down the pipeline
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic             last;
      logic [N_W-1:0]   n;
   } tag_type;

endpackage

@@ hw/rtl/lut_walsh_fourier_spectrum.sv @@
// Top level of the LUT Walsh-Hadamard spectrum block: sequencer, 64 lanes,
// merge stage and output register. Depends on lwfs_pkg, lwfs_lane, lwfs_merge.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata: truth_table, input_count
//  rsp     | out | rsp_tvalid/tready    | tdata: subset_index, coefficient; tlast
//
// Each table gives 2^n coefficients, one per cycle while rsp is not stalled; a
// table holds the input side while the sequencer steps the subset index.
// All 64 lanes evaluate one subset per cycle unless stalled; the merge registers
// per-group counts, sums them combinationally and feeds the output register.
// Reset (synchronous, active high) empties the sequencer and the pipeline.
// A stall on rsp freezes the whole pipeline; nothing is dropped.
module lut_walsh_fourier_spectrum
   import lwfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [63:0] truth_table, [66:64] input_count, [71:67] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [5:0] subset_index, [13:6] coefficient, [15:14] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic             busy_ff;
   logic             busy_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic [IDX_W-1:0] mask_ff;
   logic [IDX_W-1:0] mask_in;
   logic [N_W-1:0]   n_ff;
   logic [N_W-1:0]   n_in;
   logic [LANES-1:0] table_ff;
   logic [LANES-1:0] table_in;
   logic [N_W-1:0]   req_n;
   logic [IDX_W:0]   req_size;
   logic             req_fire;
   logic             en;
   logic             issue_last;
   tag_type          s1_ff;
   tag_type          s2_tag;
   logic [LANES-1:0] neg;
   logic [COEF_W-1:0] coef;
   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic [COEF_W-1:0] rsp_coef_ff;
   logic              rsp_last_ff;

   // Pipeline advances when the output register can take a new item
   assign en         = ~rsp_valid_ff | rsp_tready;
   assign req_tready = ~busy_ff;
   assign req_fire   = req_tvalid & req_tready;
   assign issue_last = (idx_ff == mask_ff);

   // Clamp the input count and build the index mask
   always_comb begin
      req_n = req_tdata[66:64];
      if (req_n > N_W'(MAX_INPUTS)) begin
         req_n = N_W'(MAX_INPUTS);
      end
      req_size = (IDX_W+1)'(1) << req_n;
   end

   // Sequencer next state
   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      mask_in  = mask_ff;
      n_in     = n_ff;
      table_in = table_ff;
      if (req_fire) begin
         busy_in  = 1'b1;
         idx_in   = '0;
         n_in     = req_n;
         mask_in  = IDX_W'(req_size - (IDX_W+1)'(1));
         table_in = req_tdata[LANES-1:0];
      end else if (busy_ff && en) begin
         idx_in = idx_ff + IDX_W'(1);
         if (issue_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      mask_ff  <= mask_in;
      n_ff     <= n_in;
      table_ff <= table_in;
   end

   // Lane stage tag
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (en) begin
         s1_ff.valid <= busy_ff;
      end
      if (en) begin
         s1_ff.idx  <= idx_ff;
         s1_ff.last <= issue_last;
         s1_ff.n    <= n_ff;
      end
   end

   // One lane per table entry
   for (genvar j = 0; j < LANES; j++) begin : g_lane
      lwfs_lane u_lane (
         .clock     (clock),
         .en        (en),
         .lane_id   (IDX_W'(j)),
         .idx       (idx_ff),
         .mask      (mask_ff),
         .table_bit (table_ff[j]),
         .neg_ff    (neg[j])
      );
   end

   lwfs_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .neg         (neg),
      .tag_in      (s1_ff),
      .tag_out     (s2_tag),
      .coefficient (coef)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s2_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_idx_ff  <= s2_tag.idx;
         rsp_coef_ff <= coef;
         rsp_last_ff <= s2_tag.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_coef_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // An accepted table starts the sequencer
   a_fire_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> busy_ff)
      else $error("sequencer not busy after accept");

   // Coefficient stays within -1.0 .. 1.0
   a_coef_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(rsp_coef_ff) >= -8'sd64 && $signed(rsp_coef_ff) <= 8'sd64))
      else $error("coefficient out of range");

   // A stall freezes the lane stage
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(s1_ff) && $stable(neg))
      else $error("lane stage moved during stall");

   // Last mark sits on the final index of the table
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      (s1_ff.valid && s1_ff.last) |-> (s1_ff.idx == IDX_W'(((IDX_W+1)'(1) << s1_ff.n) - 1)))
      else $error("last mark on wrong index");
`endif

endmodule

@@ hw/rtl/lwfs_lane.sv @@
// One lane of the spectrum datapath: sign of one table entry for the current subset.
// Depends on lwfs_pkg.
module lwfs_lane
   import lwfs_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [IDX_W-1:0] lane_id,
   input  logic [IDX_W-1:0] idx,
   input  logic [IDX_W-1:0] mask,
   input  logic             table_bit,
   output logic             neg_ff
);

   logic neg_in;
   logic in_range;

   // Entry counts only when its position lies inside the table
   assign in_range = ((lane_id & ~mask) == '0);
   assign neg_in   = in_range & (table_bit ^ (^(idx & lane_id)));

   // Hold while the pipeline is stalled
   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff <= neg_in;
      end
   end

endmodule

@@ hw/rtl/lwfs_merge.sv @@
// Merge stage: counts negative entries over all lanes and scales to a coefficient.
// Depends on lwfs_pkg.
module lwfs_merge
   import lwfs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [LANES-1:0]  neg,
   input  tag_type           tag_in,
   output tag_type           tag_out,
   output logic [COEF_W-1:0] coefficient
);

   logic [GCNT_W-1:0] grp_cnt_ff [GROUPS];
   logic [GCNT_W-1:0] grp_cnt_in [GROUPS];
   tag_type           tag_ff;
   logic [TOTAL_W-1:0] total;
   logic [13:0]        shifted;
   logic [8:0]         coef_wide;
   logic [N_W-1:0]     shamt;

   // Count each group of lanes
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_cnt_in[g] = '0;
         for (int b = 0; b < GROUP_SIZE; b++) begin
            grp_cnt_in[g] = grp_cnt_in[g] + GCNT_W'(neg[g*GROUP_SIZE + b]);
         end
      end
   end

   // Register group counts
   always_ff @(posedge clock) begin
      if (en) begin
         for (int g = 0; g < GROUPS; g++) begin
            grp_cnt_ff[g] <= grp_cnt_in[g];
         end
      end
   end

   // Advance the tag with the counts
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else if (en) begin
         tag_ff.valid <= tag_in.valid;
      end
      if (en) begin
         tag_ff.idx  <= tag_in.idx;
         tag_ff.last <= tag_in.last;
         tag_ff.n    <= tag_in.n;
      end
   end

   // Sum groups, coefficient = 64 - count * 2^(7-n)
   always_comb begin
      total = '0;
      for (int g = 0; g < GROUPS; g++) begin
         total = total + TOTAL_W'(grp_cnt_ff[g]);
      end
      shamt     = N_W'(7) - tag_ff.n;
      shifted   = {7'd0, total} << shamt;
      coef_wide = 9'd64 - shifted[8:0];
   end

   assign coefficient = coef_wide[COEF_W-1:0];
   assign tag_out     = tag_ff;

endmodule

@@ verif/lut_walsh_fourier_spectrum_tb.sv @@
// Self-checking testbench for lut_walsh_fourier_spectrum: drives truth tables,
// predicts each Walsh-Hadamard spectrum and checks every coefficient in order.
// Depends on lwfs_pkg and the block's RTL only.
`timescale 1ns / 100ps

module lut_walsh_fourier_spectrum_tb;
   import lwfs_pkg::*;

   localparam int N_DIR     = 20;
   localparam int N_RAND    = 450;
   localparam int HOLD_LEN  = 400;
   localparam int TAIL_WAIT = 16;

   // One coefficient as it should leave the block
   typedef struct packed {
      logic [IDX_W-1:0]         idx;
      logic signed [COEF_W-1:0] coef;
      logic                     last;
   } coef_rec_type;

   // Directed stimulus row; typed rows carry the DC term, all others are zero
   typedef struct packed {
      logic [63:0]              tbl;
      logic [N_W-1:0]           n;
      logic                     typed;
      logic signed [COEF_W-1:0] dc;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   coef_rec_type spectrum_q[$];
   int           mismatch_cnt = 0;
   bit           calm         = 1'b0;
   bit           stall_ask    = 1'b0;

   dir_row_type dir_rows [N_DIR] = '{
      '{64'h0000_0000_0000_0000, 3'd0, 1'b1,  8'sd64},
      '{64'h0000_0000_0000_0001, 3'd0, 1'b1, -8'sd64},
      '{64'hFFFF_FFFF_FFFF_FFFE, 3'd0, 1'b1,  8'sd64},
      '{64'h0000_0000_0000_0000, 3'd6, 1'b1,  8'sd64},
      '{64'hFFFF_FFFF_FFFF_FFFF, 3'd6, 1'b1, -8'sd64},
      '{64'h0000_0000_0000_0000, 3'd7, 1'b1,  8'sd64},
      '{64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 1'b1, -8'sd64},
      '{64'h0000_0000_0000_00FF, 3'd3, 1'b1, -8'sd64},
      '{64'hFFFF_FFFF_FFFF_FF00, 3'd3, 1'b1,  8'sd64},
      '{64'h6996_9669_9669_6996, 3'd6, 1'b0,  8'sd0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 3'd6, 1'b0,  8'sd0},
      '{64'h8000_0000_0000_0000, 3'd6, 1'b0,  8'sd0},
      '{64'h0000_0000_0000_0008, 3'd2, 1'b0,  8'sd0},
      '{64'h0000_0000_0000_0006, 3'd2, 1'b0,  8'sd0},
      '{64'hFFFF_FFFF_FFFF_FFFE, 3'd2, 1'b0,  8'sd0},
      '{64'h0123_4567_89AB_CDEF, 3'd7, 1'b0,  8'sd0},
      '{64'hFEDC_BA98_7654_3210, 3'd5, 1'b0,  8'sd0},
      '{64'h0000_0000_0000_0002, 3'd1, 1'b0,  8'sd0},
      '{64'h5A5A_5A5A_5A5A_F0A5, 3'd4, 1'b0,  8'sd0},
      '{64'h3C5A_96E1_0F78_D2B4, 3'd6, 1'b0,  8'sd0}
   };

   lut_walsh_fourier_spectrum dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Clamp the input count to the widest table the block supports
   function automatic int unsigned clamp_inputs(logic [N_W-1:0] n);
      return (n > MAX_INPUTS) ? MAX_INPUTS : n;
   endfunction

   // Fourier coefficient i of a table with n inputs, scaled to 6 fraction bits
   function automatic logic signed [COEF_W-1:0] walsh_coef(logic [63:0] tbl,
                                                          int unsigned n,
                                                          int unsigned i);
      int          sum;
      int          scaled;
      logic [5:0]  mask;
      sum = 0;
      for (int unsigned j = 0; j < (1 << n); j++) begin
         mask = i[5:0] & j[5:0];
         if (tbl[j] ^ (^mask)) sum = sum - 1;
         else sum = sum + 1;
      end
      scaled = sum * (1 << (6 - n));
      return scaled[COEF_W-1:0];
   endfunction

   function automatic bit idle_pick();
      return !calm && ($urandom_range(99) < 20);
   endfunction

   // Queue the whole spectrum of one accepted table
   task automatic push_spectrum(input logic [63:0] tbl, input logic [N_W-1:0] n,
                                input logic typed, input logic signed [COEF_W-1:0] dc);
      int unsigned  n_sat;
      int unsigned  size;
      coef_rec_type rec;
      n_sat = clamp_inputs(n);
      size  = 1 << n_sat;
      for (int unsigned i = 0; i < size; i++) begin
         rec.idx  = i[IDX_W-1:0];
         rec.last = (i == size - 1);
         if (typed) rec.coef = (i == 0) ? dc : '0;
         else rec.coef = walsh_coef(tbl, n_sat, i);
         spectrum_q = {spectrum_q, rec};
      end
   endtask

   // Offer one table, starting just after a falling edge; return after the next one
   task automatic offer_table(input logic [63:0] tbl, input logic [N_W-1:0] n,
                              input logic typed, input logic signed [COEF_W-1:0] dc);
      while (idle_pick()) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = {{(REQ_DATA_W-N_W-64){1'b0}}, n, tbl};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      push_spectrum(tbl, n, typed, dc);
      @(negedge clock);
   endtask

   // Receiver: random back-pressure, one long hold-off on request
   initial begin
      int held;
      bit hold_done;
      held      = 0;
      hold_done = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (stall_ask && !hold_done) begin
            rsp_tready = 1'b0;
            held++;
            if (held == HOLD_LEN) hold_done = 1'b1;
         end else begin
            rsp_tready = calm ? 1'b1 : ($urandom_range(99) >= 20);
         end
         @(negedge clock);
      end
   end

   // Compare each accepted coefficient with the oldest expectation
   always @(posedge clock) begin
      coef_rec_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (spectrum_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("unexpected coefficient: idx %0d coef %0d last %0b",
                        rsp_tdata[5:0], $signed(rsp_tdata[13:6]), rsp_tlast);
         end else begin
            want = spectrum_q.pop_front();
            if (rsp_tdata[5:0] !== want.idx || rsp_tdata[13:6] !== want.coef ||
                rsp_tdata[15:14] !== 2'b00 || rsp_tlast !== want.last) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("mismatch: exp %0d/%0d/%0b, got %0d/%0d/%0b pad %b",
                           want.idx, want.coef, want.last, rsp_tdata[5:0],
                           $signed(rsp_tdata[13:6]), rsp_tlast, rsp_tdata[15:14]);
            end
         end
      end
   end

   // Stimulus: directed rows, then random tables
   initial begin
      logic [63:0]    tbl;
      logic [N_W-1:0] n;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < N_DIR; r++)
         offer_table(dir_rows[r].tbl, dir_rows[r].n, dir_rows[r].typed, dir_rows[r].dc);

      // Drain the directed part before the random run
      req_tvalid = 1'b0;
      while (spectrum_q.size() != 0) @(negedge clock);

      for (int k = 0; k < N_RAND; k++) begin
         calm = (k >= 40 && k < 110);
         if (k == 180) stall_ask = 1'b1;
         if (k == 320) begin
            req_tvalid = 1'b0;
            while (spectrum_q.size() != 0) @(negedge clock);
         end
         tbl = {$urandom, $urandom};
         n   = N_W'($urandom_range(7));
         offer_table(tbl, n, 1'b0, 8'sd0);
      end
      req_tvalid = 1'b0;
      calm       = 1'b0;

      // Wait for the last spectrum, then a few more cycles for strays
      while (spectrum_q.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);

      if (mismatch_cnt == 0 && spectrum_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
